FILE: rtl/core/slpo_pkg.sv
`timescale 1ns / 1ps

package slpo_pkg;

    localparam logic [26:0] MAX_PHASE_MS = 27'd86400000;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_STATUS   = 3'd1,
        OP_REPORT   = 3'd2,
        OP_SYSTEM   = 3'd3,
        OP_OVERRIDE = 3'd4,
        OP_RELEASE  = 3'd5,
        OP_AUTO     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        REQ_ADMIN    = 2'd0,
        REQ_REPORTER = 2'd1,
        REQ_OTHER    = 2'd2
    } requester_t;

    typedef enum logic [1:0] {
        RC_OK      = 2'd0,
        RC_INVALID = 2'd1,
        RC_DENIED  = 2'd2
    } result_code_t;

    typedef enum logic [1:0] {
        OWN_SYSTEM = 2'd0,
        OWN_REPORT = 2'd1,
        OWN_MANUAL = 2'd2
    } owner_t;

    localparam logic [2:0] SYS_RESET_COLOR = 3'd3;
    localparam logic [2:0] REP_RESET_COLOR = 3'd4;

    typedef struct packed {
        logic [2:0]  color_a;
        logic [2:0]  color_b;
        logic [26:0] dur_a;
        logic [26:0] dur_b;
    } pattern_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  requester;
        logic [2:0]  color_first;
        logic [2:0]  color_second;
        logic [26:0] first_ms;
        logic [26:0] second_ms;
        logic        led_disabled;
        logic        startup_done;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  result_code;
        logic [2:0]  led_color;
        logic [1:0]  owner;
        logic [26:0] ms_to_change;
    } rsp_item_t;

    // Decoded command: what the item does to the stored state
    typedef struct packed {
        logic [1:0] code;
        logic       wr_report;
        logic       wr_system;
        logic       wr_manual;
        logic       set_auto;
        logic       clr_auto;
        logic       set_override;
        logic       clr_override;
        pattern_t   pat;
    } cmd_upd_t;

    function automatic logic pat_alternates(input pattern_t p);
        return (p.dur_a != 27'd0) && (p.color_a != p.color_b);
    endfunction

endpackage

FILE: rtl/core/slpo_cmd.sv
`timescale 1ns / 1ps

module slpo_cmd
    import slpo_pkg::*;
(
    input  req_item_t item,
    output cmd_upd_t  upd
);

    logic admin;
    logic reporter;
    logic pat_ok;

    assign admin    = (item.requester == REQ_ADMIN);
    assign reporter = (item.requester == REQ_REPORTER);

    // steady pattern needs equal colors; a blinking one needs both phases
    always_comb
    begin
        pat_ok = (item.first_ms <= MAX_PHASE_MS) && (item.second_ms <= MAX_PHASE_MS)
            && (((item.first_ms == 27'd0) && (item.second_ms == 27'd0)
                 && (item.color_first == item.color_second))
                || ((item.first_ms != 27'd0) && (item.second_ms != 27'd0)));
    end

    always_comb
    begin
        upd              = '0;
        upd.code         = RC_OK;
        upd.pat.color_a  = item.color_first;
        upd.pat.color_b  = item.color_second;
        upd.pat.dur_a    = item.first_ms;
        upd.pat.dur_b    = item.second_ms;
        if (item.opcode inside {OP_TICK, OP_STATUS})
        begin
            upd.code = RC_OK;
        end
        else if ((item.opcode == OP_REPORT) && (admin || reporter))
        begin
            upd.code      = pat_ok ? RC_OK : RC_INVALID;
            upd.wr_report = pat_ok;
        end
        else if (!admin)
        begin
            upd.code = RC_DENIED;
        end
        else
        begin
            case (item.opcode)
                OP_SYSTEM:
                begin
                    upd.code         = pat_ok ? RC_OK : RC_INVALID;
                    upd.wr_system    = pat_ok;
                    upd.clr_auto     = pat_ok;
                    upd.clr_override = pat_ok;
                end
                OP_OVERRIDE:
                begin
                    upd.code         = pat_ok ? RC_OK : RC_INVALID;
                    upd.wr_manual    = pat_ok;
                    upd.set_override = pat_ok;
                end
                OP_RELEASE:
                begin
                    upd.clr_override = 1'b1;
                end
                OP_AUTO:
                begin
                    upd.set_auto     = 1'b1;
                    upd.clr_override = 1'b1;
                end
                default:
                begin
                    upd.code = RC_INVALID;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/status_led_pattern_owner_unit.sv
`timescale 1ns / 1ps
// Channel | Signals                          | Direction | Item
// req     | req_valid, req_ready, req_item   | in        | command or ms tick
// rsp     | rsp_valid, rsp_ready, rsp_item   | out       | one result per item
//
// One item per cycle sustained while rsp_ready holds; the item is captured in the request register,
// then its result in the result register, around the update logic.
// Reset leaves flags clear, default patterns loaded and no active pattern.
// A stalled result holds the request register; req_ready stays high while the
// request register is empty or moves on in the same cycle.

module status_led_pattern_owner_unit
    import slpo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    req_item_t   req_reg;
    logic        req_valid_reg;
    rsp_item_t   rsp_reg;
    rsp_item_t   rsp_next;
    logic        rsp_valid_reg;
    logic        advance;

    logic        auto_mode_reg,      auto_mode_next;
    logic        override_on_reg,    override_on_next;
    pattern_t    system_pat_reg,     system_pat_next;
    pattern_t    report_pat_reg,     report_pat_next;
    pattern_t    manual_pat_reg,     manual_pat_next;
    pattern_t    active_pat_reg,     active_pat_next;
    logic        active_loaded_reg;
    logic        active_alt_reg,     active_alt_next;
    logic [27:0] active_cycle_reg,   active_cycle_next;
    logic [27:0] phase_count_reg,    phase_count_next;

    cmd_upd_t    upd;
    pattern_t    want;
    logic        load;
    logic [27:0] phase_inc;
    logic [27:0] delay_wide;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    slpo_cmd u_cmd
    (
        .item (req_reg),
        .upd  (upd)
    );

    // command effects on flags and stored patterns
    always_comb
    begin
        auto_mode_next   = (auto_mode_reg || upd.set_auto) && !upd.clr_auto;
        override_on_next = (override_on_reg || upd.set_override) && !upd.clr_override;
        system_pat_next  = upd.wr_system ? upd.pat : system_pat_reg;
        report_pat_next  = upd.wr_report ? upd.pat : report_pat_reg;
        manual_pat_next  = upd.wr_manual ? upd.pat : manual_pat_reg;
    end

    // effective pattern by priority
    always_comb
    begin
        if (req_reg.led_disabled)
            want = '0;
        else if (auto_mode_next && !req_reg.startup_done)
            want = system_pat_next;
        else if (override_on_next)
            want = manual_pat_next;
        else if (auto_mode_next)
            want = report_pat_next;
        else
            want = system_pat_next;
    end

    assign load      = !active_loaded_reg || (want != active_pat_reg);
    assign phase_inc = phase_count_reg + 28'd1;

    always_comb
    begin
        active_pat_next   = active_pat_reg;
        active_alt_next   = active_alt_reg;
        active_cycle_next = active_cycle_reg;
        phase_count_next  = phase_count_reg;
        if (load)
        begin
            active_pat_next   = want;
            active_alt_next   = pat_alternates(want);
            active_cycle_next = {1'b0, want.dur_a} + {1'b0, want.dur_b};
            phase_count_next  = '0;
        end
        else if (req_reg.opcode == OP_TICK)
        begin
            if (active_alt_reg && (phase_inc < active_cycle_reg))
                phase_count_next = phase_inc;
            else
                phase_count_next = '0;
        end
    end

    always_comb
    begin
        rsp_next.result_code = upd.code;
        delay_wide           = '0;
        rsp_next.led_color   = active_pat_next.color_a;
        if (active_alt_next)
        begin
            if (phase_count_next < {1'b0, active_pat_next.dur_a})
            begin
                delay_wide = {1'b0, active_pat_next.dur_a} - phase_count_next;
            end
            else
            begin
                rsp_next.led_color = active_pat_next.color_b;
                delay_wide         = active_cycle_next - phase_count_next;
            end
        end
        rsp_next.ms_to_change = delay_wide[26:0];
        if (override_on_next)
            rsp_next.owner = OWN_MANUAL;
        else if (auto_mode_next)
            rsp_next.owner = OWN_REPORT;
        else
            rsp_next.owner = OWN_SYSTEM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg     <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            auto_mode_reg     <= 1'b0;
            override_on_reg   <= 1'b0;
            system_pat_reg    <= '{color_a: SYS_RESET_COLOR, color_b: SYS_RESET_COLOR,
                                   dur_a: 27'd0, dur_b: 27'd0};
            report_pat_reg    <= '{color_a: REP_RESET_COLOR, color_b: REP_RESET_COLOR,
                                   dur_a: 27'd0, dur_b: 27'd0};
            manual_pat_reg    <= '0;
            active_pat_reg    <= '0;
            active_loaded_reg <= 1'b0;
            active_alt_reg    <= 1'b0;
            active_cycle_reg  <= '0;
            phase_count_reg   <= '0;
        end
        else
        begin
            if (req_ready)
                req_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (advance)
            begin
                auto_mode_reg     <= auto_mode_next;
                override_on_reg   <= override_on_next;
                system_pat_reg    <= system_pat_next;
                report_pat_reg    <= report_pat_next;
                manual_pat_reg    <= manual_pat_next;
                active_pat_reg    <= active_pat_next;
                active_loaded_reg <= 1'b1;
                active_alt_reg    <= active_alt_next;
                active_cycle_reg  <= active_cycle_next;
                phase_count_reg   <= phase_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req_item;
        if (advance)
            rsp_reg <= rsp_next;
    end

    a_phase_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        active_alt_reg |-> (phase_count_reg < active_cycle_reg))
        else $error("phase count outside pattern cycle");

    a_steady_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !active_alt_reg |-> (phase_count_reg == 28'd0))
        else $error("steady pattern with nonzero phase");

    a_cycle_matches: assert property (@(posedge clk) disable iff (!rst_n)
        active_cycle_reg == ({1'b0, active_pat_reg.dur_a} + {1'b0, active_pat_reg.dur_b}))
        else $error("stored cycle length out of step with active pattern");

    a_loaded_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        active_loaded_reg |=> active_loaded_reg)
        else $error("active pattern dropped");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("processed item produced no result");

endmodule
